@@ rtl/qrs_pkg.sv @@
// Shared constants and types for the quadratic root solver.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int OUT_BITS        = 34;
   localparam int STEPS_PER_STAGE = 2;

   typedef struct packed {
      logic neg_first;
      logic neg_second;
      logic cplx;
      logic degen;
   } flags_type;

endpackage

@@ rtl/qrs_sqrt.sv @@
// Pipelined fixed-point square root: floor(sqrt(mag * 2^(2*FRAC_BITS))).
// Two result bits per stage; a sideband vector travels with each transaction. Uses qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt #(
   parameter int MAG_BITS  = 33,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic [MAG_BITS-1:0]                   in_mag,
   input  logic [SIDE_BITS-1:0]                  in_side,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic [(MAG_BITS+1)/2+FRAC_BITS-1:0]   out_root,
   output logic [SIDE_BITS-1:0]                  out_side
);
   localparam int STEPS     = qrs_pkg::STEPS_PER_STAGE;
   localparam int ROOT_BITS = (MAG_BITS + 1) / 2 + FRAC_BITS;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int STAGES    = (ROOT_BITS + STEPS - 1) / STEPS;

   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    adv;
   logic [RAD_BITS-1:0]  rad_ff  [STAGES];
   logic [RAD_BITS-1:0]  rad_in  [STAGES];
   logic [REM_BITS-1:0]  rem_ff  [STAGES];
   logic [REM_BITS-1:0]  rem_in  [STAGES];
   logic [ROOT_BITS-1:0] root_ff [STAGES];
   logic [ROOT_BITS-1:0] root_in [STAGES];
   logic [SIDE_BITS-1:0] side_ff [STAGES];
   logic [SIDE_BITS-1:0] side_in [STAGES];

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !out_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [REM_BITS-1:0]  trial;
      logic [ROOT_BITS-1:0] root;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            rad        = RAD_BITS'(in_mag) << (2 * FRAC_BITS);
            rem        = '0;
            root       = '0;
            side_in[k] = in_side;
         end else begin
            rad        = rad_ff[k-1];
            rem        = rem_ff[k-1];
            root       = root_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < ROOT_BITS) begin
               rem   = {rem[REM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
               rad   = rad << 2;
               trial = {root, 2'b01};
               if (rem >= trial) begin
                  rem  = rem - trial;
                  root = {root[ROOT_BITS-2:0], 1'b1};
               end else begin
                  root = {root[ROOT_BITS-2:0], 1'b0};
               end
            end
         end
         rad_in[k]  = rad;
         rem_in[k]  = rem;
         root_in[k] = root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

@@ rtl/qrs_div.sv @@
// Pipelined unsigned restoring divider: two numerators over one shared divisor.
// Two quotient bits per stage; a sideband vector travels along. Uses qrs_pkg.
`timescale 1ns / 1ps
module qrs_div #(
   parameter int NUM_BITS  = 34,
   parameter int DEN_BITS  = 17,
   parameter int SIDE_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [NUM_BITS-1:0]  in_num_first,
   input  logic [NUM_BITS-1:0]  in_num_second,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [NUM_BITS-1:0]  out_quo_first,
   output logic [NUM_BITS-1:0]  out_quo_second,
   output logic [SIDE_BITS-1:0] out_side
);
   localparam int STEPS  = qrs_pkg::STEPS_PER_STAGE;
   localparam int STAGES = (NUM_BITS + STEPS - 1) / STEPS;

   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    adv;
   logic [NUM_BITS-1:0]  num_ff  [STAGES][2];
   logic [NUM_BITS-1:0]  num_in  [STAGES][2];
   logic [DEN_BITS-1:0]  rem_ff  [STAGES][2];
   logic [DEN_BITS-1:0]  rem_in  [STAGES][2];
   logic [DEN_BITS-1:0]  den_ff  [STAGES];
   logic [DEN_BITS-1:0]  den_in  [STAGES];
   logic [SIDE_BITS-1:0] side_ff [STAGES];
   logic [SIDE_BITS-1:0] side_in [STAGES];

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || !out_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      logic [NUM_BITS-1:0] n;
      logic [DEN_BITS-1:0] rem;
      logic [DEN_BITS:0]   wide;
      for (int k = 0; k < STAGES; k++) begin
         den_in[k]  = (k == 0) ? in_den  : den_ff[k-1];
         side_in[k] = (k == 0) ? in_side : side_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            if (k == 0) begin
               n   = (l == 0) ? in_num_first : in_num_second;
               rem = '0;
            end else begin
               n   = num_ff[k-1][l];
               rem = rem_ff[k-1][l];
            end
            for (int j = 0; j < STEPS; j++) begin
               if (k * STEPS + j < NUM_BITS) begin
                  wide = {rem, n[NUM_BITS-1]};
                  n    = {n[NUM_BITS-2:0], 1'b0};
                  if (wide >= {1'b0, den_in[k]}) begin
                     wide = wide - {1'b0, den_in[k]};
                     n[0] = 1'b1;
                  end
                  rem = wide[DEN_BITS-1:0];
               end
            end
            num_in[k][l] = n;
            rem_in[k][l] = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_in[k];
            for (int l = 0; l < 2; l++) begin
               num_ff[k][l] <= num_in[k][l];
               rem_ff[k][l] <= rem_in[k][l];
            end
         end
      end
   end

   assign in_stall       = !adv[0];
   assign out_valid      = valid_ff[STAGES-1];
   assign out_quo_first  = num_ff[STAGES-1][0];
   assign out_quo_second = num_ff[STAGES-1][1];
   assign out_side       = side_ff[STAGES-1];

endmodule

@@ rtl/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: discriminant, square root, division, output.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_coef_a, req_coef_b, req_coef_c
//   rsp_      out        rsp_valid/rsp_stall  rsp_first_/second_ real/imag,
//                                             rsp_roots_complex, rsp_degenerate
//
// One transaction per cycle sustained while rsp_stall stays low. Registers in order:
//   stage A, stage B, the square root pipeline, stage N, stage M, the divider pipeline
// and the output stage; the square root and divider pipelines produce two bits per stage.
// Reset clears only the valid bits. A stall holds each full stage; empty stages keep filling.
`timescale 1ns / 1ps
module quadratic_root_solver #(
   parameter int COEF_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COEF_BITS-1:0]         req_coef_a,
   input  logic signed [COEF_BITS-1:0]         req_coef_b,
   input  logic signed [COEF_BITS-1:0]         req_coef_c,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_first_real,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_first_imag,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_second_real,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_second_imag,
   output logic                                rsp_roots_complex,
   output logic                                rsp_degenerate
);
   localparam int OUT_BITS   = qrs_pkg::OUT_BITS;
   localparam int PROD_BITS  = 2 * COEF_BITS;
   localparam int D_BITS     = 2 * COEF_BITS + 2;
   localparam int MAG_BITS   = 2 * COEF_BITS + 1;
   localparam int NB_BITS    = COEF_BITS + FRAC_BITS + 1;
   localparam int DEN_BITS   = COEF_BITS + 1;
   localparam int ROOT_BITS  = (MAG_BITS + 1) / 2 + FRAC_BITS;
   localparam int SIDE_BITS  = NB_BITS + DEN_BITS + 3;
   localparam int NUMS_BITS  = COEF_BITS + FRAC_BITS + 3;
   localparam int NUM_BITS   = COEF_BITS + FRAC_BITS + 2;
   localparam int VAL_BITS   = NUM_BITS + 1;
   localparam int FLAG_BITS  = $bits(qrs_pkg::flags_type);
   localparam int SAT_BITS   = ((VAL_BITS > OUT_BITS) ? VAL_BITS : OUT_BITS) + 1;
   localparam logic signed [SAT_BITS-1:0] SAT_HI =
      (SAT_BITS'(1) <<< (OUT_BITS - 1)) - SAT_BITS'(1);
   localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_HI - SAT_BITS'(1);

   function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [VAL_BITS-1:0] v);
      logic signed [SAT_BITS-1:0] w;
      w = SAT_BITS'(v);
      if (w > SAT_HI) begin
         w = SAT_HI;
      end else if (w < SAT_LO) begin
         w = SAT_LO;
      end
      return OUT_BITS'(w);
   endfunction

   // stage A: products
   logic                        va_ff;
   logic signed [COEF_BITS-1:0] a_ff, b_ff;
   logic signed [PROD_BITS-1:0] bb_ff, ac_ff, bb_in, ac_in;
   // stage B: discriminant and operands
   logic                        vb_ff;
   logic signed [D_BITS-1:0]    d_in;
   logic [MAG_BITS-1:0]         mag_ff, mag_in;
   logic signed [NB_BITS-1:0]   nb_in;
   logic signed [DEN_BITS-1:0]  abs_a;
   logic [DEN_BITS-1:0]         dmag_in;
   logic [SIDE_BITS-1:0]        side_b_ff, side_b_in;
   // square root
   logic                        sq_in_stall, sq_valid;
   logic [ROOT_BITS-1:0]        sq_root;
   logic [SIDE_BITS-1:0]        sq_side;
   logic signed [NB_BITS-1:0]   sq_nb;
   logic [DEN_BITS-1:0]         sq_dmag;
   logic                        sq_dneg, sq_cplx, sq_degen;
   logic signed [NUMS_BITS-1:0] root_s, nb_s;
   // stage N: signed numerators
   logic                        vn_ff;
   logic signed [NUMS_BITS-1:0] n1_ff, n2_ff, n1_in, n2_in;
   logic [DEN_BITS-1:0]         dmag_n_ff;
   logic                        dneg_n_ff, cplx_n_ff, degen_n_ff;
   // stage M: magnitudes and quotient signs
   logic                        vm_ff;
   logic [NUM_BITS-1:0]         m1_ff, m2_ff, m1_in, m2_in;
   logic [DEN_BITS-1:0]         dmag_m_ff;
   qrs_pkg::flags_type          flags_m_ff, flags_m_in;
   // divider
   logic                        dv_in_stall, dv_valid;
   logic [NUM_BITS-1:0]         q1, q2;
   logic [FLAG_BITS-1:0]        dv_side;
   qrs_pkg::flags_type          dv_flags;
   logic signed [VAL_BITS-1:0]  q1_s, q2_s, v1, v2, w2;
   // output stage
   logic                        rsp_valid_ff;
   logic signed [OUT_BITS-1:0]  r1_ff, i1_ff, r2_ff, i2_ff, r1_in, i1_in, r2_in, i2_in;
   logic                        cplx_ff, degen_ff;
   logic                        en_a, en_b, en_n, en_m, en_out;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_m      = !vm_ff || !dv_in_stall;
   assign en_n      = !vn_ff || en_m;
   assign en_b      = !vb_ff || !sq_in_stall;
   assign en_a      = !va_ff || en_b;
   assign req_stall = !en_a;

   assign bb_in = req_coef_b * req_coef_b;
   assign ac_in = req_coef_a * req_coef_c;

   assign d_in      = D_BITS'(bb_ff) - (D_BITS'(ac_ff) <<< 2);
   assign mag_in    = d_in[D_BITS-1] ? MAG_BITS'(-d_in) : MAG_BITS'(d_in);
   assign nb_in     = -(NB_BITS'(b_ff) <<< FRAC_BITS);
   assign abs_a     = a_ff[COEF_BITS-1] ? -DEN_BITS'(a_ff) : DEN_BITS'(a_ff);
   assign dmag_in   = {abs_a[COEF_BITS-1:0], 1'b0};
   assign side_b_in = {nb_in, dmag_in, a_ff[COEF_BITS-1], d_in[D_BITS-1], a_ff == '0};

   qrs_sqrt #(
      .MAG_BITS  (MAG_BITS),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_BITS (SIDE_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vb_ff),
      .in_stall  (sq_in_stall),
      .in_mag    (mag_ff),
      .in_side   (side_b_ff),
      .out_valid (sq_valid),
      .out_stall (!en_n),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_nb, sq_dmag, sq_dneg, sq_cplx, sq_degen} = sq_side;
   assign root_s = NUMS_BITS'(sq_root);
   assign nb_s   = NUMS_BITS'(sq_nb);
   assign n1_in  = sq_cplx ? nb_s : nb_s + root_s;
   assign n2_in  = sq_cplx ? root_s : nb_s - root_s;

   assign m1_in = n1_ff[NUMS_BITS-1] ? NUM_BITS'(-n1_ff) : NUM_BITS'(n1_ff);
   assign m2_in = n2_ff[NUMS_BITS-1] ? NUM_BITS'(-n2_ff) : NUM_BITS'(n2_ff);
   assign flags_m_in.neg_first  = n1_ff[NUMS_BITS-1] ^ dneg_n_ff;
   assign flags_m_in.neg_second = n2_ff[NUMS_BITS-1] ^ dneg_n_ff;
   assign flags_m_in.cplx       = cplx_n_ff && !degen_n_ff;
   assign flags_m_in.degen      = degen_n_ff;

   qrs_div #(
      .NUM_BITS  (NUM_BITS),
      .DEN_BITS  (DEN_BITS),
      .SIDE_BITS (FLAG_BITS)
   ) u_div (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (vm_ff),
      .in_stall       (dv_in_stall),
      .in_num_first   (m1_ff),
      .in_num_second  (m2_ff),
      .in_den         (dmag_m_ff),
      .in_side        (flags_m_ff),
      .out_valid      (dv_valid),
      .out_stall      (!en_out),
      .out_quo_first  (q1),
      .out_quo_second (q2),
      .out_side       (dv_side)
   );

   assign dv_flags = qrs_pkg::flags_type'(dv_side);
   assign q1_s     = VAL_BITS'(q1);
   assign q2_s     = VAL_BITS'(q2);
   assign v1       = dv_flags.neg_first  ? -q1_s : q1_s;
   assign v2       = dv_flags.neg_second ? -q2_s : q2_s;
   assign w2       = dv_flags.neg_second ? q2_s : -q2_s;

   always_comb begin
      r1_in = sat(v1);
      r2_in = sat(v2);
      i1_in = '0;
      i2_in = '0;
      if (dv_flags.cplx) begin
         r2_in = sat(v1);
         i1_in = sat(v2);
         i2_in = sat(w2);
      end
      if (dv_flags.degen) begin
         r1_in = '0;
         r2_in = '0;
         i1_in = '0;
         i2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vn_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= req_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_n) begin
            vn_ff <= sq_valid;
         end
         if (en_m) begin
            vm_ff <= vn_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= dv_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ff  <= req_coef_a;
         b_ff  <= req_coef_b;
         bb_ff <= bb_in;
         ac_ff <= ac_in;
      end
      if (en_b) begin
         mag_ff    <= mag_in;
         side_b_ff <= side_b_in;
      end
      if (en_n) begin
         n1_ff      <= n1_in;
         n2_ff      <= n2_in;
         dmag_n_ff  <= sq_dmag;
         dneg_n_ff  <= sq_dneg;
         cplx_n_ff  <= sq_cplx;
         degen_n_ff <= sq_degen;
      end
      if (en_m) begin
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         dmag_m_ff  <= dmag_n_ff;
         flags_m_ff <= flags_m_in;
      end
      if (en_out) begin
         r1_ff    <= r1_in;
         i1_ff    <= i1_in;
         r2_ff    <= r2_in;
         i2_ff    <= i2_in;
         cplx_ff  <= dv_flags.cplx;
         degen_ff <= dv_flags.degen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_real    = r1_ff;
   assign rsp_first_imag    = i1_ff;
   assign rsp_second_real   = r2_ff;
   assign rsp_second_imag   = i2_ff;
   assign rsp_roots_complex = cplx_ff;
   assign rsp_degenerate    = degen_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> va_ff)
      else $error("input stalled with an empty first stage");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_roots_complex && rsp_first_real == '0
         && rsp_second_real == '0 && rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("degenerate transaction carries nonzero roots");

   a_real_no_imag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_roots_complex |-> rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("real roots carry an imaginary part");

   a_conjugate_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_roots_complex |-> rsp_first_real == rsp_second_real)
      else $error("conjugate pair with differing real parts");

endmodule

@@ bench/quadratic_root_solver_checker.sv @@
// Checker for the quadratic root solver: watches both channels, predicts roots, compares.
// Depends on qrs_pkg for OUT_BITS; instantiated beside the block by quadratic_root_solver_test.
`timescale 1ns / 1ps
module quadratic_root_solver_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [15:0]                  req_coef_a,
   input  logic signed [15:0]                  req_coef_b,
   input  logic signed [15:0]                  req_coef_c,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [qrs_pkg::OUT_BITS-1:0] rsp_first_real,
   input  logic signed [qrs_pkg::OUT_BITS-1:0] rsp_first_imag,
   input  logic signed [qrs_pkg::OUT_BITS-1:0] rsp_second_real,
   input  logic signed [qrs_pkg::OUT_BITS-1:0] rsp_second_imag,
   input  logic                                rsp_roots_complex,
   input  logic                                rsp_degenerate,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  root_count,
   output int                                  complex_count
);
   localparam int FRAC = 16;
   localparam int OB = qrs_pkg::OUT_BITS;

   typedef struct packed {
      logic signed [OB-1:0] first_real;
      logic signed [OB-1:0] first_imag;
      logic signed [OB-1:0] second_real;
      logic signed [OB-1:0] second_imag;
      logic                 cplx;
      logic                 degen;
   } roots_type;

   roots_type expected_roots[$];

   function automatic longint unsigned fixed_sqrt(longint unsigned v);
      longint unsigned rem, root, trial, pair;
      rem = 0;
      root = 0;
      for (int i = 31; i >= -FRAC; i--) begin
         pair = (i >= 0) ? ((v >> (2 * i)) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic signed [OB-1:0] clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (OB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OB-1:0];
   endfunction

   function automatic roots_type solve_roots(longint a, longint b, longint c);
      roots_type r;
      longint d, den, nb, s, r1, r2, i1;
      r = '0;
      if (a != 0) begin
         d = b * b - 4 * a * c;
         den = 2 * a;
         nb = -b * (longint'(1) <<< FRAC);
         if (d >= 0) begin
            s = longint'(fixed_sqrt(d));
            r1 = (nb + s) / den;
            r2 = (nb - s) / den;
            r.first_real = clamp(r1);
            r.second_real = clamp(r2);
         end else begin
            s = longint'(fixed_sqrt(-d));
            r1 = nb / den;
            i1 = s / den;
            r.cplx = 1'b1;
            r.first_real = clamp(r1);
            r.second_real = clamp(r1);
            r.first_imag = clamp(i1);
            r.second_imag = clamp(-i1);
         end
      end else begin
         r.degen = 1'b1;
      end
      return r;
   endfunction

   assign pending = expected_roots.size();

   always @(posedge clock) begin
      roots_type want, got;
      if (reset) begin
         fail_count <= 0;
         root_count <= 0;
         complex_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_roots.push_back(solve_roots(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_first_real, rsp_first_imag, rsp_second_real, rsp_second_imag,
                    rsp_roots_complex, rsp_degenerate};
            root_count <= root_count + 1;
            if (rsp_roots_complex) complex_count <= complex_count + 1;
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h", $realtime,
                        got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected fr=%0d fi=%0d sr=%0d si=%0d c=%0b d=%0b",
                           $realtime, want.first_real, want.first_imag, want.second_real,
                           want.second_imag, want.cplx, want.degen);
                  $display("%0t:            actual fr=%0d fi=%0d sr=%0d si=%0d c=%0b d=%0b",
                           $realtime, got.first_real, got.first_imag, got.second_real,
                           got.second_imag, got.cplx, got.degen);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ bench/quadratic_root_solver_test.sv @@
// Testbench top for the quadratic root solver: clock, reset, stimulus and verdict.
// Depends on quadratic_root_solver (rtl) and quadratic_root_solver_checker.
`timescale 1ns / 1ps
module quadratic_root_solver_test;
   localparam int OB = qrs_pkg::OUT_BITS;
   localparam int RANDOM_SETS = 1730;
   localparam int CALM_TAIL = 200;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [15:0] req_coef_a, req_coef_b, req_coef_c;
   logic signed [OB-1:0] rsp_first_real, rsp_first_imag, rsp_second_real, rsp_second_imag;
   logic rsp_roots_complex, rsp_degenerate;
   int fail_count, pending, root_count, complex_count;
   bit calm;

   quadratic_root_solver u_top (.*);
   quadratic_root_solver_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && !reset && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_set(logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         3: return 16'(int'($urandom_range(0, 400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] a, b, c, k;
      int drain;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_set(0, 5, 3);
      send_set(0, 16'sh8000, 16'sh7fff);
      send_set(1, 0, 0);
      send_set(1, -2, 1);
      send_set(1, -3, 2);
      send_set(1, 0, 1);
      send_set(2, 2, 5);
      send_set(-1, 0, 4);
      send_set(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_set(16'sh8000, 16'sh8000, 16'sh8000);
      send_set(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_set(16'sh7fff, 16'sh8000, 16'sh8000);
      send_set(1, 16'sh8000, 16'sh8000);
      send_set(1, 16'sh7fff, 16'sh7fff);
      send_set(-1, 16'sh8000, 16'sh7fff);
      send_set(16'sh7fff, 0, 16'sh7fff);
      send_set(16'sh8000, 0, 16'sh8000);
      send_set(3, 7, -11);
      send_set(-5, -1, -9);
      send_set(16'sh5555, 16'shaaaa, 16'sh5555);
      for (int n = 0; n < RANDOM_SETS; n++) begin
         if (n == RANDOM_SETS - CALM_TAIL) calm = 1'b1;
         a = pick_coef();
         b = pick_coef();
         c = pick_coef();
         if ($urandom_range(0, 7) == 0) begin
            // perfect square: a*(x-k)^2 gives D = 0
            k = 16'(int'($urandom_range(0, 20)) - 10);
            a = 16'(int'($urandom_range(1, 9)));
            b = 16'(-2 * a * k);
            c = 16'(a * k * k);
         end
         send_set(a, b, c);
      end
      req_valid <= 1'b0;
      drain = 0;
      while (pending != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (60) @(posedge clock);
      $display("Ran %0d coefficient sets; %0d root results checked, %0d complex pairs.",
               RANDOM_SETS + 20, root_count, complex_count);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

@@ quadratic_root_solver.f @@
rtl/qrs_pkg.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
bench/quadratic_root_solver_checker.sv
bench/quadratic_root_solver_test.sv
